// File: design/prbf_pkg.sv
// ----------------------------------------------------------------------------
// prbf_pkg
// Shared types, constants and helpers of the packet repetition budget filter.
// ----------------------------------------------------------------------------
`default_nettype none

package prbf_pkg;

    localparam int WINDOW     = 64;
    localparam int EXTRA_SCAN = 16;
    localparam int MAX_PACKET = 4096;
    localparam int SCAN_END   = WINDOW + EXTRA_SCAN;
    localparam int SLOT_W     = $clog2(WINDOW);

    localparam logic [31:0] RNG_SEED = 32'hDEADBEEF;

    localparam int BUDGET_W   = 20;
    localparam int SQ_W       = 13;
    localparam int LEN_W      = 13;
    localparam int POS_W      = 13;
    localparam int STREAK_W   = 16;
    localparam int DIVIDEND_W = 37;

    localparam logic [SQ_W-1:0]     SQUARE_THRESHOLD_RST  = 13'd1024;
    localparam logic [BUDGET_W-1:0] LEVEL_ONE_BOUND_RST   = 20'd19200;
    localparam logic [BUDGET_W-1:0] LEVEL_TWO_BOUND_RST   = 20'd12800;
    localparam logic [BUDGET_W-1:0] LEVEL_THREE_BOUND_RST = 20'd6400;
    localparam logic [BUDGET_W-1:0] BUDGET_CEILING_RST    = 20'd25600;
    localparam logic [BUDGET_W-1:0] RECOVERY_STEP_RST     = 20'd256;
    localparam logic [BUDGET_W-1:0] PENALTY_GAIN_RST      = 20'd2560;
    localparam logic [STREAK_W-1:0] STREAK_LIMIT_RST      = 16'd10;

    localparam logic [6:0] DRAW_MOD       = 7'd100;
    localparam logic [6:0] DRAW_LIM_NORM  = 7'd10;
    localparam logic [6:0] DRAW_LIM_ELEV  = 7'd50;

    // floor(x / 100) = (x * DRAW_RECIP) >> DRAW_SHIFT for every 32-bit x
    localparam logic [31:0] DRAW_RECIP = 32'h51EB851F;
    localparam int          DRAW_SHIFT = 37;
    localparam int          DRAW_QUO_W = 26;

    typedef enum logic [2:0] {
        CFG_SQUARE_THRESHOLD  = 3'd0,
        CFG_LEVEL_ONE_BOUND   = 3'd1,
        CFG_LEVEL_TWO_BOUND   = 3'd2,
        CFG_LEVEL_THREE_BOUND = 3'd3,
        CFG_BUDGET_CEILING    = 3'd4,
        CFG_RECOVERY_STEP     = 3'd5,
        CFG_PENALTY_GAIN      = 3'd6,
        CFG_STREAK_LIMIT      = 3'd7
    } cfg_index_t;

    typedef enum logic [1:0] {
        LVL_NORMAL      = 2'd0,
        LVL_ELEVATED    = 2'd1,
        LVL_CONSTRAINED = 2'd2,
        LVL_QUARANTINE  = 2'd3
    } level_t;

    typedef struct packed {
        logic [7:0]       data_byte;
        logic [LEN_W-1:0] packet_length;
        logic             last_byte;
    } pkt_word_t;

    typedef struct packed {
        logic                anomalous;
        logic                inspected;
        logic [SQ_W-1:0]     peak_square_sum;
        logic [1:0]          level_used;
        logic [BUDGET_W-1:0] budget_after;
    } res_word_t;

    function automatic level_t level_of(
        input logic [BUDGET_W-1:0] budget,
        input logic [BUDGET_W-1:0] b1,
        input logic [BUDGET_W-1:0] b2,
        input logic [BUDGET_W-1:0] b3
    );
        level_t lv;
        if (budget > b1)      lv = LVL_NORMAL;
        else if (budget > b2) lv = LVL_ELEVATED;
        else if (budget > b3) lv = LVL_CONSTRAINED;
        else                  lv = LVL_QUARANTINE;
        return lv;
    endfunction

    function automatic logic [31:0] xorshift32(input logic [31:0] w);
        logic [31:0] x;
        x = w;
        x = x ^ (x << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        return x;
    endfunction

endpackage

`default_nettype wire

// File: design/packet_repetition_budget_filter.sv
// ----------------------------------------------------------------------------
// packet_repetition_budget_filter
// Byte-stream histogram scanner with a sampled, budgeted inspection policy.
// ----------------------------------------------------------------------------
// One byte at a time; an unscanned byte passes SCAN, FIN, a scanned one also NEWRD,
// NEWWR, and OLD, OLDWR once it also removes a byte (count read-modify-write for
// each byte). A sampled packet's first byte at level 0 or 1 adds DRAW, DREM (draw
// mod 100). A last byte adds OUT, anomalous ones MUL, DIVGO, DIV (37-step divider).
// Reset: asynchronous, clears control; budget takes the ceiling reset value.
// ----------------------------------------------------------------------------
`default_nettype none

module packet_repetition_budget_filter (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       pkt_valid,
    output logic                            pkt_ready,
    input  wire prbf_pkg::pkt_word_t        pkt_word,
    output logic                            res_valid,
    input  wire logic                       res_ready,
    output prbf_pkg::res_word_t             res_word,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [2:0]                 cfg_index,
    input  wire logic [19:0]                cfg_data
);
    import prbf_pkg::*;

    typedef enum logic [12:0] {
        ST_IDLE  = 13'b0000000000001,
        ST_DRAW  = 13'b0000000000010,
        ST_SCAN  = 13'b0000000000100,
        ST_OLD   = 13'b0000000001000,
        ST_OLDWR = 13'b0000000010000,
        ST_NEWRD = 13'b0000000100000,
        ST_NEWWR = 13'b0000001000000,
        ST_FIN   = 13'b0000010000000,
        ST_MUL   = 13'b0000100000000,
        ST_DIVGO = 13'b0001000000000,
        ST_DIV   = 13'b0010000000000,
        ST_OUT   = 13'b0100000000000,
        ST_DREM  = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [SQ_W-1:0]     thr_reg;
    logic [BUDGET_W-1:0] b1_reg, b2_reg, b3_reg, ceil_reg, step_reg, gain_reg;
    logic [STREAK_W-1:0] limit_reg;

    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [POS_W-1:0]    cur_pos_reg;
    logic [7:0]          cur_byte_reg;
    logic                cur_last_reg;
    logic [7:0]          old_reg;
    logic                long_reg, long_next;
    logic                insp_reg, insp_next;
    logic                stop_reg, stop_next;
    logic [SQ_W-1:0]     sum_reg, sum_next;
    logic [SQ_W-1:0]     peak_reg, peak_next;
    logic [31:0]         rng_reg, rng_next;
    logic [BUDGET_W-1:0] budget_reg, budget_next;
    logic [STREAK_W-1:0] clean_reg, clean_next;
    logic [63:0]         draw_prod_reg;
    logic                dnorm_reg, dnorm_next;
    logic                anom_reg, anom_next;
    logic [1:0]          lvl_reg, lvl_next;
    logic [32:0]         prod_reg;
    logic                res_valid_reg, res_valid_next;
    res_word_t           res_word_reg;

    // ring and count memories
    logic [7:0]          ring_mem [WINDOW];
    logic [7:0]          ring_rdata;
    logic                ring_we;
    logic [SLOT_W-1:0]   slot;
    logic [6:0]          cnt_mem [256];
    logic [6:0]          cnt_rdata;
    logic                cnt_rvld;
    logic                cnt_re, cnt_we;
    logic [7:0]          cnt_raddr, cnt_waddr;
    logic [6:0]          cnt_wdata;
    logic [255:0]        cnt_valid_reg;
    logic                cnt_clear;

    logic [6:0]          c_val;
    logic [DRAW_QUO_W-1:0] draw_quo;
    logic [31:0]         draw_rem;
    logic [BUDGET_W+3:0] rec_sum;
    logic [BUDGET_W+2:0] rec_step;
    logic [STREAK_W-1:0] clean_inc;
    logic [SQ_W-1:0]     sum_add;
    level_t              lv_start;
    logic                pkt_acc;
    logic                div_start, div_done;
    logic [DIVIDEND_W-1:0] div_q, dividend;

    assign pkt_acc   = pkt_valid && pkt_ready;
    assign pkt_ready = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign slot      = SLOT_W'(cur_pos_reg % WINDOW);
    assign c_val     = cnt_rvld ? cnt_rdata : 7'd0;
    assign lv_start  = level_of(budget_reg, b1_reg, b2_reg, b3_reg);
    assign draw_quo  = draw_prod_reg[DRAW_SHIFT +: DRAW_QUO_W];
    assign draw_rem  = rng_reg - (32'(draw_quo) * 32'(DRAW_MOD));
    assign clean_inc = (clean_reg != {STREAK_W{1'b1}}) ? clean_reg + 1'b1 : clean_reg;
    assign dividend  = (DIVIDEND_W'(prod_reg) << 3) + (DIVIDEND_W'(prod_reg) << 1);
    assign sum_add   = sum_reg + SQ_W'({c_val, 1'b1});

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        long_next      = long_reg;
        insp_next      = insp_reg;
        stop_next      = stop_reg;
        sum_next       = sum_reg;
        peak_next      = peak_reg;
        rng_next       = rng_reg;
        budget_next    = budget_reg;
        clean_next     = clean_reg;
        dnorm_next     = dnorm_reg;
        anom_next      = anom_reg;
        lvl_next       = lvl_reg;
        res_valid_next = res_valid_reg && !res_ready;
        ring_we        = 1'b0;
        cnt_re         = 1'b0;
        cnt_we         = 1'b0;
        cnt_raddr      = cur_byte_reg;
        cnt_waddr      = cur_byte_reg;
        cnt_wdata      = 7'd0;
        cnt_clear      = 1'b0;
        div_start      = 1'b0;
        rec_step       = '0;
        rec_sum        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (pkt_acc)
                begin
                    if (pkt_word.last_byte)         pos_next = '0;
                    else if (pos_reg < SCAN_END)    pos_next = pos_reg + 1'b1;
                    state_next = ST_SCAN;
                    if (pos_reg == '0)
                    begin
                        cnt_clear = 1'b1;
                        sum_next  = '0;
                        peak_next = '0;
                        stop_next = 1'b0;
                        insp_next = 1'b0;
                        long_next = (pkt_word.packet_length >= LEN_W'(WINDOW));
                        if (pkt_word.packet_length >= LEN_W'(WINDOW))
                        begin
                            if (lv_start == LVL_NORMAL || lv_start == LVL_ELEVATED)
                            begin
                                rng_next   = xorshift32(rng_reg);
                                dnorm_next = (lv_start == LVL_NORMAL);
                                state_next = ST_DRAW;
                            end
                            else
                            begin
                                insp_next = 1'b1;
                            end
                        end
                    end
                end
            end
            ST_DRAW:
            begin
                // hold while the reciprocal product settles
                state_next = ST_DREM;
            end
            ST_DREM:
            begin
                insp_next  = dnorm_reg ? (draw_rem[6:0] < DRAW_LIM_NORM)
                                       : (draw_rem[6:0] < DRAW_LIM_ELEV);
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (insp_reg && !stop_reg && cur_pos_reg < SCAN_END)
                begin
                    if (cur_pos_reg >= WINDOW) state_next = ST_OLD;
                    else                       state_next = ST_NEWRD;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_OLD:
            begin
                cnt_re     = 1'b1;
                cnt_raddr  = ring_rdata;
                state_next = ST_OLDWR;
            end
            ST_OLDWR:
            begin
                if (c_val != 7'd0)
                begin
                    cnt_we    = 1'b1;
                    cnt_waddr = old_reg;
                    cnt_wdata = c_val - 1'b1;
                    sum_next  = sum_reg - SQ_W'({c_val, 1'b0} - 8'd1);
                end
                state_next = ST_NEWRD;
            end
            ST_NEWRD:
            begin
                ring_we    = 1'b1;
                cnt_re     = 1'b1;
                state_next = ST_NEWWR;
            end
            ST_NEWWR:
            begin
                cnt_we    = 1'b1;
                cnt_wdata = c_val + 1'b1;
                sum_next  = sum_add;
                if (cur_pos_reg >= POS_W'(WINDOW - 1))
                begin
                    if (sum_add > peak_reg) peak_next = sum_add;
                    if (sum_add > thr_reg)  stop_next = 1'b1;
                end
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!cur_last_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    lvl_next   = level_of(budget_reg, b1_reg, b2_reg, b3_reg);
                    anom_next  = 1'b0;
                    state_next = ST_OUT;
                    if (!long_reg)
                    begin
                        rec_step = (BUDGET_W+3)'(step_reg);
                    end
                    else if (insp_reg && peak_reg > thr_reg)
                    begin
                        anom_next  = 1'b1;
                        clean_next = '0;
                        if (thr_reg == '0)  budget_next = '0;
                        else                state_next  = ST_MUL;
                    end
                    else
                    begin
                        clean_next = clean_inc;
                        if (clean_inc > limit_reg)
                            rec_step = ((BUDGET_W+3)'(step_reg) << 2)
                                     + ((BUDGET_W+3)'(step_reg) << 1);
                        else
                            rec_step = (BUDGET_W+3)'(step_reg);
                    end
                    if (!(long_reg && insp_reg && peak_reg > thr_reg))
                    begin
                        rec_sum = {4'd0, budget_reg} + {1'b0, rec_step};
                        if (rec_sum > {4'd0, ceil_reg}) budget_next = ceil_reg;
                        else                            budget_next = rec_sum[BUDGET_W-1:0];
                    end
                end
            end
            ST_MUL:
            begin
                state_next = ST_DIVGO;
            end
            ST_DIVGO:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if (div_q >= DIVIDEND_W'(budget_reg)) budget_next = '0;
                    else budget_next = budget_reg - div_q[BUDGET_W-1:0];
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            long_reg      <= 1'b0;
            insp_reg      <= 1'b0;
            stop_reg      <= 1'b0;
            sum_reg       <= '0;
            peak_reg      <= '0;
            rng_reg       <= RNG_SEED;
            budget_reg    <= BUDGET_CEILING_RST;
            clean_reg     <= '0;
            res_valid_reg <= 1'b0;
            thr_reg       <= SQUARE_THRESHOLD_RST;
            b1_reg        <= LEVEL_ONE_BOUND_RST;
            b2_reg        <= LEVEL_TWO_BOUND_RST;
            b3_reg        <= LEVEL_THREE_BOUND_RST;
            ceil_reg      <= BUDGET_CEILING_RST;
            step_reg      <= RECOVERY_STEP_RST;
            gain_reg      <= PENALTY_GAIN_RST;
            limit_reg     <= STREAK_LIMIT_RST;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            long_reg      <= long_next;
            insp_reg      <= insp_next;
            stop_reg      <= stop_next;
            sum_reg       <= sum_next;
            peak_reg      <= peak_next;
            rng_reg       <= rng_next;
            budget_reg    <= budget_next;
            clean_reg     <= clean_next;
            res_valid_reg <= res_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_SQUARE_THRESHOLD:  thr_reg   <= cfg_data[SQ_W-1:0];
                    CFG_LEVEL_ONE_BOUND:   b1_reg    <= cfg_data;
                    CFG_LEVEL_TWO_BOUND:   b2_reg    <= cfg_data;
                    CFG_LEVEL_THREE_BOUND: b3_reg    <= cfg_data;
                    CFG_BUDGET_CEILING:    ceil_reg  <= cfg_data;
                    CFG_RECOVERY_STEP:     step_reg  <= cfg_data;
                    CFG_PENALTY_GAIN:      gain_reg  <= cfg_data;
                    CFG_STREAK_LIMIT:      limit_reg <= cfg_data[STREAK_W-1:0];
                    default:               thr_reg   <= thr_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        draw_prod_reg <= rng_reg * DRAW_RECIP;
        dnorm_reg <= dnorm_next;
        anom_reg  <= anom_next;
        lvl_reg   <= lvl_next;
        prod_reg  <= 33'(peak_reg - thr_reg) * 33'(gain_reg);
        if (pkt_acc)
        begin
            cur_pos_reg  <= pos_reg;
            cur_byte_reg <= pkt_word.data_byte;
            cur_last_reg <= pkt_word.last_byte;
        end
        if (state_reg == ST_OLD)
        begin
            old_reg <= ring_rdata;
        end
        if (state_reg == ST_OUT && (!res_valid_reg || res_ready))
        begin
            res_word_reg.anomalous       <= anom_reg;
            res_word_reg.inspected       <= insp_reg;
            res_word_reg.peak_square_sum <= peak_reg;
            res_word_reg.level_used      <= lvl_reg;
            res_word_reg.budget_after    <= budget_reg;
        end
    end

    // ring memory: read old slot on entering a scan, write the new byte later
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[slot] <= cur_byte_reg;
        end
        ring_rdata <= ring_mem[slot];
    end

    // count memory with per-entry valid bits, cleared at packet start
    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cnt_re)
        begin
            cnt_rdata <= cnt_mem[cnt_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_valid_reg <= '0;
            cnt_rvld      <= 1'b0;
        end
        else
        begin
            if (cnt_clear)
            begin
                cnt_valid_reg <= '0;
            end
            else if (cnt_we)
            begin
                cnt_valid_reg[cnt_waddr] <= 1'b1;
            end
            if (cnt_re)
            begin
                cnt_rvld <= cnt_valid_reg[cnt_raddr];
            end
        end
    end

    prbf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (thr_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

endmodule

`default_nettype wire

// File: design/prbf_div.sv
// ----------------------------------------------------------------------------
// prbf_div
// Restoring divider, one quotient bit per cycle, for the penalty drain.
// ----------------------------------------------------------------------------
`default_nettype none

module prbf_div (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic [prbf_pkg::DIVIDEND_W-1:0]    dividend,
    input  wire logic [prbf_pkg::SQ_W-1:0]          divisor,
    output logic                                    done,
    output logic [prbf_pkg::DIVIDEND_W-1:0]         quotient
);
    import prbf_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quot_reg, quot_next;
    logic [SQ_W:0]         rem_reg, rem_next;
    logic [SQ_W-1:0]       dvs_reg;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [SQ_W:0]         rem_sh;

    always_comb
    begin
        rem_sh    = {rem_reg[SQ_W-1:0], quot_reg[DIVIDEND_W-1]};
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quot_next = dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(DIVIDEND_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift one dividend bit in, subtract when it fits
            if (rem_sh >= {1'b0, dvs_reg})
            begin
                rem_next  = rem_sh - {1'b0, dvs_reg};
                quot_next = {quot_reg[DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                quot_next = {quot_reg[DIVIDEND_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

`default_nettype wire

// File: design/prbf_checker.sv
// ----------------------------------------------------------------------------
// prbf_checker
// Port-level checks of the packet repetition budget filter.
// ----------------------------------------------------------------------------
`default_nettype none

module prbf_checker (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  pkt_valid,
    input wire logic                  pkt_ready,
    input wire logic                  res_valid,
    input wire logic                  res_ready,
    input wire prbf_pkg::res_word_t   res_word,
    input wire logic                  cfg_ready
);
    import prbf_pkg::*;

    // hold a stalled result word
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_word))
        else $error("result word changed while stalled");

    // advance one byte at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_valid && pkt_ready |=> !pkt_ready)
        else $error("byte accepted back to back");

    a_anom_inspected: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (!res_word.anomalous || res_word.inspected))
        else $error("anomalous packet not inspected");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("config port not ready");

endmodule

bind packet_repetition_budget_filter prbf_checker u_prbf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pkt_valid (pkt_valid),
    .pkt_ready (pkt_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_word  (res_word),
    .cfg_ready (cfg_ready)
);

`default_nettype wire

// File: dv/packet_repetition_budget_filter_tb.sv
// ----------------------------------------------------------------------------
// packet_repetition_budget_filter_tb
// Drives packet bytes through the filter with random gaps and receiver
// stalls. A scoreboard models the histogram scan, the sampling draw and the
// budget updates, and checks every result word field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module packet_repetition_budget_filter_tb;
    import prbf_pkg::*;

    class filter_scoreboard;
        bit [SQ_W-1:0]     sq_thr;
        bit [BUDGET_W-1:0] bound1, bound2, bound3, ceiling, step, gain;
        bit [STREAK_W-1:0] streak_lim;
        bit [7:0]          ring[WINDOW];
        bit [6:0]          counts[256];
        int unsigned       sq_sum, pos, peak, flags;
        bit [31:0]         rng;
        bit [BUDGET_W-1:0] budget;
        int unsigned       clean;
        res_word_t         pending_results[$];
        int                errors;

        function new();
            sq_thr = SQUARE_THRESHOLD_RST;
            bound1 = LEVEL_ONE_BOUND_RST;
            bound2 = LEVEL_TWO_BOUND_RST;
            bound3 = LEVEL_THREE_BOUND_RST;
            ceiling = BUDGET_CEILING_RST;
            step = RECOVERY_STEP_RST;
            gain = PENALTY_GAIN_RST;
            streak_lim = STREAK_LIMIT_RST;
            sq_sum = 0; pos = 0; peak = 0; flags = 0;
            rng = RNG_SEED;
            budget = BUDGET_CEILING_RST;
            clean = 0;
            errors = 0;
        endfunction

        function void set_reg(cfg_index_t idx, bit [19:0] d);
            case (idx)
                CFG_SQUARE_THRESHOLD:  sq_thr = d[SQ_W-1:0];
                CFG_LEVEL_ONE_BOUND:   bound1 = d;
                CFG_LEVEL_TWO_BOUND:   bound2 = d;
                CFG_LEVEL_THREE_BOUND: bound3 = d;
                CFG_BUDGET_CEILING:    ceiling = d;
                CFG_RECOVERY_STEP:     step = d;
                CFG_PENALTY_GAIN:      gain = d;
                default:               streak_lim = d[STREAK_W-1:0];
            endcase
        endfunction

        function level_t budget_level();
            if (budget > bound1) return LVL_NORMAL;
            if (budget > bound2) return LVL_ELEVATED;
            if (budget > bound3) return LVL_CONSTRAINED;
            return LVL_QUARANTINE;
        endfunction

        function bit [31:0] next_draw();
            bit [31:0] x;
            x = rng;
            x = x ^ (x << 13);
            x = x ^ (x >> 17);
            x = x ^ (x << 5);
            rng = x;
            return x;
        endfunction

        function void regain(longint unsigned amount);
            longint unsigned b;
            b = longint'(budget) + amount;
            if (b > ceiling) b = ceiling;
            budget = b[BUDGET_W-1:0];
        endfunction

        function void scan(bit [7:0] b);
            int unsigned slot, c;
            bit [7:0] old;
            slot = pos % WINDOW;
            if (pos >= WINDOW) begin
                old = ring[slot];
                c = counts[old];
                if (c > 0) begin
                    sq_sum = sq_sum - (2 * c - 1);
                    counts[old] = c - 1;
                end
            end
            ring[slot] = b;
            c = counts[b];
            sq_sum = (sq_sum + 2 * c + 1) & 32'h1FFF;
            counts[b] = (c + 1) & 32'h7F;
            if (pos + 1 >= WINDOW) begin
                if (sq_sum > peak) peak = sq_sum;
                if (sq_sum > sq_thr) flags |= 4;
            end
        endfunction

        function void note_word(pkt_word_t w);
            level_t lv;
            res_word_t r;
            longint unsigned drain;
            bit anom;
            if (pos == 0) begin
                foreach (counts[i]) counts[i] = 0;
                sq_sum = 0; peak = 0; flags = 0;
                if (w.packet_length >= WINDOW) begin
                    lv = budget_level();
                    flags = 1;
                    if (lv == LVL_NORMAL) begin
                        if (next_draw() % 100 < 10) flags |= 2;
                    end else if (lv == LVL_ELEVATED) begin
                        if (next_draw() % 100 < 50) flags |= 2;
                    end else begin
                        flags |= 2;
                    end
                end
            end
            if (flags[1] && !flags[2] && pos < SCAN_END) scan(w.data_byte);
            if (pos < SCAN_END) pos++;
            if (!w.last_byte) return;
            lv = budget_level();
            anom = 0;
            if (!flags[0]) begin
                regain(step);
            end else begin
                anom = flags[1] && peak > sq_thr;
                if (anom) begin
                    clean = 0;
                    if (sq_thr == 0) begin
                        budget = 0;
                    end else begin
                        drain = longint'(peak - sq_thr) * gain * 10 / sq_thr;
                        budget = (drain >= budget) ? 0 : budget - drain;
                    end
                end else begin
                    if (clean < 16'hFFFF) clean++;
                    regain(clean > streak_lim ? longint'(step) * 6 : longint'(step));
                end
            end
            r.anomalous = anom;
            r.inspected = flags[1];
            r.peak_square_sum = peak[SQ_W-1:0];
            r.level_used = lv;
            r.budget_after = budget;
            pending_results.push_back(r);
            pos = 0;
            flags = 0;
        endfunction

        function void check_result(res_word_t got);
            res_word_t e;
            if (pending_results.size() == 0) begin
                $error("result word with no pending packet: %h", got);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            if (got.anomalous !== e.anomalous) begin
                $error("anomalous exp %0d got %0d", e.anomalous, got.anomalous);
                errors++;
            end
            if (got.inspected !== e.inspected) begin
                $error("inspected exp %0d got %0d", e.inspected, got.inspected);
                errors++;
            end
            if (got.peak_square_sum !== e.peak_square_sum) begin
                $error("peak_square_sum exp %0d got %0d", e.peak_square_sum,
                       got.peak_square_sum);
                errors++;
            end
            if (got.level_used !== e.level_used) begin
                $error("level_used exp %0d got %0d", e.level_used, got.level_used);
                errors++;
            end
            if (got.budget_after !== e.budget_after) begin
                $error("budget_after exp %0d got %0d", e.budget_after, got.budget_after);
                errors++;
            end
        endfunction
    endclass

    localparam int STALL_LIMIT = 20000;

    logic              clk = 0;
    logic              rst_n = 0;
    logic              pkt_valid = 0;
    logic              pkt_ready;
    pkt_word_t         pkt_word = '0;
    logic              res_valid;
    logic              res_ready = 0;
    res_word_t         res_word;
    logic              cfg_valid = 0;
    logic              cfg_ready;
    logic [2:0]        cfg_index = '0;
    logic [19:0]       cfg_data = '0;

    filter_scoreboard sb = new();
    bit hold_req = 0;
    bit tx_steady = 0;
    int idle_cycles = 0;

    packet_repetition_budget_filter u_dut (
        .clk(clk), .rst_n(rst_n),
        .pkt_valid(pkt_valid), .pkt_ready(pkt_ready), .pkt_word(pkt_word),
        .res_valid(res_valid), .res_ready(res_ready), .res_word(res_word),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 92) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge clk) begin
        if (pkt_valid && pkt_ready) sb.note_word(pkt_word);
        if (res_valid && res_ready) sb.check_result(res_word);
        if ((pkt_valid && pkt_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        wait (rst_n);
        forever begin
            @(posedge clk);
            if (hold_req) begin
                res_ready <= 0;
                repeat (400) @(posedge clk);
                hold_req = 0;
                res_ready <= 1;
            end else if (!tx_steady && $urandom_range(0, 3) == 0) begin
                res_ready <= 0;
                repeat (gap_len()) @(posedge clk);
                res_ready <= 1;
            end else begin
                res_ready <= 1;
            end
        end
    end

    task automatic send_word(pkt_word_t w, bit hold_after);
        pkt_valid <= 1;
        pkt_word <= w;
        do @(posedge clk); while (!pkt_ready);
        if (!hold_after) begin
            pkt_valid <= 0;
            repeat (gap_len()) @(posedge clk);
        end
    endtask

    // mode 0: uniform bytes; otherwise bytes from a small alphabet of width mode
    task automatic send_packet(int nbytes, int len_field, int mode);
        pkt_word_t w;
        bit [7:0] base;
        base = $urandom_range(0, 255);
        for (int i = 0; i < nbytes; i++) begin
            w.data_byte = (mode == 0) ? 8'($urandom_range(0, 255))
                                      : 8'(base + $urandom_range(0, mode - 1));
            w.packet_length = len_field;
            w.last_byte = (i == nbytes - 1);
            send_word(w, tx_steady || $urandom_range(0, 99) < 60);
        end
    endtask

    task automatic wait_drain();
        pkt_valid <= 0;
        @(posedge clk);
        while (sb.pending_results.size() != 0) @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, bit [19:0] d);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= d;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 0;
        sb.set_reg(idx, d);
        @(posedge clk);
    endtask

    task automatic random_packet();
        int n, len, mode, r;
        r = $urandom_range(0, 99);
        mode = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 24);
        if (r < 88) n = $urandom_range(1, 6);
        else n = $urandom_range(WINDOW, SCAN_END + 12);
        len = n;
        if ($urandom_range(0, 9) == 0) len = $urandom_range(0, MAX_PACKET);
        else if ($urandom_range(0, 19) == 0) len = MAX_PACKET;
        send_packet(n, len, mode);
    endtask

    function automatic bit [19:0] pick20(int phase);
        if (phase == 1) return 20'hFFFFF;
        if (phase == 2) return 20'd0;
        return $urandom_range(0, 20'hFFFFF);
    endfunction

    initial begin
        bit [19:0] b1, b2, b3;
        int thr;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // defaults: short, boundary and mismatched lengths
        send_packet(1, 0, 0);
        send_packet(3, WINDOW - 1, 0);
        send_packet(WINDOW, WINDOW, 1);
        send_packet(5, MAX_PACKET, 0);
        send_packet(8, 10, 1);
        wait_drain();
        // force quarantine so every long packet is scanned
        write_reg(CFG_LEVEL_ONE_BOUND, 20'hFFFFF);
        write_reg(CFG_LEVEL_TWO_BOUND, 20'hFFFFF);
        write_reg(CFG_LEVEL_THREE_BOUND, 20'hFFFFF);
        send_packet(SCAN_END, SCAN_END, 1);
        send_packet(SCAN_END + 4, SCAN_END + 4, 0);
        send_packet(10, WINDOW, 1);
        wait_drain();
        write_reg(CFG_SQUARE_THRESHOLD, 20'd0);
        send_packet(WINDOW, WINDOW, 0);
        wait_drain();
        write_reg(CFG_SQUARE_THRESHOLD, 20'd4096);
        send_packet(WINDOW, WINDOW, 1);
        wait_drain();

        for (int phase = 0; phase < 8; phase++) begin
            wait_drain();
            thr = (phase == 1) ? 4096 : (phase == 2) ? 0 : $urandom_range(64, 2500);
            write_reg(CFG_SQUARE_THRESHOLD, thr);
            b1 = pick20(phase);
            b2 = (phase < 3) ? b1 : $urandom_range(0, b1);
            b3 = (phase < 3) ? b1 : $urandom_range(0, b2);
            if (phase == 0) begin
                b1 = LEVEL_ONE_BOUND_RST;
                b2 = LEVEL_TWO_BOUND_RST;
                b3 = LEVEL_THREE_BOUND_RST;
            end
            write_reg(CFG_LEVEL_ONE_BOUND, b1);
            write_reg(CFG_LEVEL_TWO_BOUND, b2);
            write_reg(CFG_LEVEL_THREE_BOUND, b3);
            write_reg(CFG_BUDGET_CEILING, (phase > 2) ? $urandom_range(0, 40000) : pick20(phase));
            write_reg(CFG_RECOVERY_STEP, (phase > 2) ? $urandom_range(0, 2000) : pick20(phase));
            write_reg(CFG_PENALTY_GAIN, (phase > 2) ? $urandom_range(0, 8000) : pick20(phase));
            write_reg(CFG_STREAK_LIMIT, (phase == 1) ? 16'hFFFF : (phase == 2) ? 0
                                                      : $urandom_range(0, 20));
            tx_steady = (phase == 4);
            if (phase == 3) hold_req = 1;
            for (int p = 0; p < 4; p++) begin
                if (phase == 5 && p == 2) wait_drain();
                random_packet();
            end
            tx_steady = 0;
        end

        wait_drain();
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
